FILE: src/assert_macros.svh
// Assertion macros included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle or later
`define EDR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Check that an expression holds at every sampled edge out of reset
`define EDR_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant check failed");

`endif

FILE: src/edr_pkg.sv
package edr_pkg;

	localparam int unsigned YearW  = 14;
	localparam int unsigned MonthW = 4;
	localparam int unsigned DayW   = 5;
	localparam int unsigned DaysW  = 22;
	localparam int unsigned QuotW  = 8;

	typedef logic [YearW-1:0]  year_t;
	typedef logic [MonthW-1:0] month_t;
	typedef logic [DayW-1:0]   day_t;
	typedef logic [DaysW-1:0]  days_t;
	typedef logic [QuotW-1:0]  quot_t;

	localparam year_t  YearMin  = 14'd1;
	localparam year_t  YearMax  = 14'd9999;
	localparam month_t MonthMin = 4'd1;
	localparam month_t MonthMax = 4'd12;
	localparam month_t MonthFeb = 4'd2;
	localparam day_t   DayMin   = 5'd1;
	localparam day_t   DayLeapFeb = 5'd29;

	// floor(x / 100) = (x * 5243) >> 19 for every x below 10000
	localparam int unsigned Recip100Shift = 19;
	localparam int unsigned ProdW         = YearW + 13;
	localparam logic [ProdW-1:0] Recip100 = 27'd5243;
	localparam logic [YearW-1:0] Hundred  = 14'd100;
	localparam days_t DaysPerYear         = 22'd365;
	localparam days_t DaysMax             = 22'd3652059;

	// Year and month after substitution and clamping, day after substitution, with
	// the quotients and year product the serial number needs
	typedef struct packed {
		year_t  y;
		month_t m;
		day_t   d;
		quot_t  qy;
		quot_t  qp;
		days_t  n365;
	} date_s2_t;

	function automatic year_t sat_year(year_t y);
		year_t r;
		if (y < YearMin) begin
			r = YearMin;
		end else if (y > YearMax) begin
			r = YearMax;
		end else begin
			r = y;
		end
		return r;
	endfunction

	function automatic month_t sat_month(month_t m);
		month_t r;
		if (m < MonthMin) begin
			r = MonthMin;
		end else if (m > MonthMax) begin
			r = MonthMax;
		end else begin
			r = m;
		end
		return r;
	endfunction

	// Common-year month length
	function automatic day_t month_len(month_t m);
		day_t r;
		case (m)
			4'd1:    r = 5'd31;
			4'd2:    r = 5'd28;
			4'd3:    r = 5'd31;
			4'd4:    r = 5'd30;
			4'd5:    r = 5'd31;
			4'd6:    r = 5'd30;
			4'd7:    r = 5'd31;
			4'd8:    r = 5'd31;
			4'd9:    r = 5'd30;
			4'd10:   r = 5'd31;
			4'd11:   r = 5'd30;
			4'd12:   r = 5'd31;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

	// Days in a common year before the first of the month
	function automatic logic [8:0] days_before(month_t m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/expiry_days_remaining.sv
// done rises with the result register and stays high for one cycle.
// Throughput: one date pair per cycle; busy stays low and the receiver cannot stall.
// Four register stages: input capture, clamp and divide by 100, serial day
// number per date, then compare and subtract into the result register.
// Reset clears the stage valid bits and done, so transfers in flight are dropped.
module expiry_days_remaining
	import edr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [13:0]  cur_year,
	input  logic [3:0]   cur_month,
	input  logic [4:0]   cur_day,
	input  logic [13:0]  exp_year,
	input  logic         exp_year_given,
	input  logic [3:0]   exp_month,
	input  logic         exp_month_given,
	input  logic [4:0]   exp_day,
	input  logic         exp_day_given,
	output logic         done,
	output logic         expired,
	output logic [21:0]  days_left
);

	logic     vld_s1, vld_s2, vld_s3;
	year_t    cur_year_s1, exp_year_s1;
	month_t   cur_month_s1, exp_month_s1;
	day_t     cur_day_s1, exp_day_s1;
	logic     exp_year_given_s1, exp_month_given_s1, exp_day_given_s1;

	year_t     y_c1 [2];
	month_t    m_c1 [2];
	day_t      d_c1 [2];
	date_s2_t  dt_c1 [2];
	date_s2_t  dt_s2 [2];
	days_t     serial_c2 [2];
	days_t     serial_s3 [2];

	logic      done_q, expired_q;
	days_t     days_left_q;

	// No stall on either side
	assign busy = 1'b0;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	// Capture the input transfer
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cur_year_s1        <= cur_year;
			cur_month_s1       <= cur_month;
			cur_day_s1         <= cur_day;
			exp_year_s1        <= exp_year;
			exp_year_given_s1  <= exp_year_given;
			exp_month_s1       <= exp_month;
			exp_month_given_s1 <= exp_month_given;
			exp_day_s1         <= exp_day;
			exp_day_given_s1   <= exp_day_given;
		end
	end

	// Clamp and substitute fields; index 0 is the current date, 1 the expiry
	always_comb begin
		y_c1[0] = sat_year(cur_year_s1);
		m_c1[0] = sat_month(cur_month_s1);
		d_c1[0] = cur_day_s1;
		y_c1[1] = exp_year_given_s1  ? sat_year(exp_year_s1)   : y_c1[0];
		m_c1[1] = exp_month_given_s1 ? sat_month(exp_month_s1) : m_c1[0];
		d_c1[1] = exp_day_given_s1   ? exp_day_s1              : DayMin;
	end

	// Divide year and year-1 by 100, and scale year-1 by 365
	for (genvar gi = 0; gi < 2; gi++) begin : g_div
		year_t             p_c1;
		logic [ProdW-1:0]  prod_y, prod_p;
		assign p_c1   = y_c1[gi] - YearMin;
		assign prod_y = ProdW'(y_c1[gi]) * Recip100;
		assign prod_p = ProdW'(p_c1) * Recip100;
		assign dt_c1[gi] = '{
			y:    y_c1[gi],
			m:    m_c1[gi],
			d:    d_c1[gi],
			qy:   prod_y[ProdW-1:Recip100Shift],
			qp:   prod_p[ProdW-1:Recip100Shift],
			n365: DaysW'(p_c1) * DaysPerYear
		};
	end

	// Hold stage 2
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			dt_s2 <= dt_c1;
		end
	end

	// Leap year, day clamp and serial day number
	for (genvar gi = 0; gi < 2; gi++) begin : g_serial
		year_t  p_c2, hund_c2;
		logic   cent_c2, leap_c2;
		day_t   lim_c2, d_c2;
		assign p_c2    = dt_s2[gi].y - YearMin;
		assign hund_c2 = YearW'(dt_s2[gi].qy) * Hundred;
		assign cent_c2 = (hund_c2 == dt_s2[gi].y);
		assign leap_c2 = cent_c2 ? (dt_s2[gi].qy[1:0] == 2'b00)
		                         : (dt_s2[gi].y[1:0] == 2'b00);
		assign lim_c2  = (dt_s2[gi].m == MonthFeb && leap_c2) ? DayLeapFeb
		                                                      : month_len(dt_s2[gi].m);
		assign d_c2    = (dt_s2[gi].d < DayMin) ? DayMin
		               : (dt_s2[gi].d > lim_c2) ? lim_c2 : dt_s2[gi].d;
		assign serial_c2[gi] = dt_s2[gi].n365
		                     + DaysW'(p_c2 >> 2)
		                     - DaysW'(dt_s2[gi].qp)
		                     + DaysW'(dt_s2[gi].qp >> 2)
		                     + DaysW'(days_before(dt_s2[gi].m))
		                     + DaysW'(dt_s2[gi].m > MonthFeb && leap_c2)
		                     + DaysW'(d_c2);
	end

	// Hold stage 3
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			serial_s3 <= serial_c2;
		end
	end

	// Compare and subtract into the result register
	always_ff @(posedge clk) begin
		if (vld_s3) begin
			if (serial_s3[1] < serial_s3[0]) begin
				expired_q   <= 1'b1;
				days_left_q <= '0;
			end else begin
				expired_q   <= 1'b0;
				days_left_q <= serial_s3[1] - serial_s3[0];
			end
		end
	end

	assign done      = done_q;
	assign expired   = expired_q;
	assign days_left = days_left_q;

endmodule

FILE: src/edr_checker.sv
`include "assert_macros.svh"

module edr_checker
	import edr_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         start,
	input logic         busy,
	input logic         done,
	input logic         expired,
	input logic [21:0]  days_left
);

	// Every accepted transfer yields a result
	`EDR_ASSERT_IMPL(a_start_done, clk, arst_n, start && !busy, ##4 done)
	// No result without an earlier accepted transfer
	`EDR_ASSERT_IMPL(a_done_start, clk, arst_n, done, $past(start && !busy, 4))
	// An expired result carries a zero count
	`EDR_ASSERT_IMPL(a_expired_zero, clk, arst_n, done && expired, days_left == '0)
	// The count never exceeds the span of the calendar
	`EDR_ASSERT_IMPL(a_days_range, clk, arst_n, done, days_left <= DaysMax)

endmodule

bind expiry_days_remaining edr_checker u_edr_checker (.*);
